// ----- hw/rtl/kbrl_pkg.sv -----
// kbrl_pkg: shared constants, state enum and control structs for the keyed batch rate limiter
// used by kbrl_ctrl, kbrl_dp and keyed_batch_rate_limiter_top
package kbrl_pkg;

  localparam int NUM_KEYS    = 8;
  localparam int QUEUE_DEPTH = 8;
  localparam int KEY_W       = $clog2(NUM_KEYS);
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_W      = $clog2(NUM_KEYS * QUEUE_DEPTH);
  localparam int STORE_DEPTH = NUM_KEYS * QUEUE_DEPTH;
  localparam int PEND_W      = 11;
  localparam int DEBT_W      = 8;
  localparam int PROC_W      = 10;
  localparam int BATCH_W     = 7;
  localparam int HW_W        = 11;

  localparam logic [PEND_W-1:0] PEND_MAX = 11'd2047;

  // register byte addresses
  localparam logic [2:0] ADDR_BATCH = 3'd0;
  localparam logic [2:0] ADDR_HIGH  = 3'd4;

  localparam logic ACT_ENQ  = 1'b0;
  localparam logic ACT_TICK = 1'b1;
  localparam logic KIND_VERDICT  = 1'b0;
  localparam logic KIND_DISPATCH = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ENQ,
    ST_TSTART,
    ST_TREAD,
    ST_TEXEC,
    ST_TEND
  } kbrl_state_t;

  typedef struct packed {
    logic latch;
    logic enq;
    logic tstart;
    logic pay;
    logic rd;
    logic disp;
    logic push_last;
    logic finish;
  } kbrl_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic out_free;
    logic any_bucket;
    logic limit_hit;
    logic it_valid;
    logic cur_debt_nz;
    logic pend_valid;
  } kbrl_stat_t;

endpackage

// ----- hw/rtl/kbrl_ctrl.sv -----
// kbrl_ctrl: sequencer for enqueue verdicts and batch tick walks
// depends on kbrl_pkg
module kbrl_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  kbrl_pkg::kbrl_stat_t stat,
  output kbrl_pkg::kbrl_cmd_t  cmd
);
  import kbrl_pkg::*;

  kbrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = ST_ENQ;
        end
      end
      ST_ENQ: begin
        // latched word decides the path
        if (stat.is_tick) begin
          state_next = ST_TSTART;
        end else if (stat.out_free) begin
          cmd.enq    = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_TSTART: begin
        if (stat.any_bucket) begin
          cmd.tstart = 1'b1;
          state_next = ST_TREAD;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_TREAD: begin
        if (stat.limit_hit || !stat.it_valid) begin
          state_next = ST_TEND;
        end else if (stat.cur_debt_nz) begin
          cmd.pay = 1'b1;
        end else begin
          cmd.rd     = 1'b1;
          state_next = ST_TEXEC;
        end
      end
      ST_TEXEC: begin
        if (!stat.pend_valid || stat.out_free) begin
          cmd.disp   = 1'b1;
          state_next = ST_TREAD;
        end
      end
      ST_TEND: begin
        if (!stat.pend_valid) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end else if (stat.out_free) begin
          cmd.push_last = 1'b1;
          cmd.finish    = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- hw/rtl/kbrl_dp.sv -----
// kbrl_dp: per-key queue state, action store, walk registers and output word register
// depends on kbrl_pkg; driven by kbrl_ctrl
module kbrl_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  kbrl_pkg::kbrl_cmd_t           cmd,
  output kbrl_pkg::kbrl_stat_t          stat,
  input  logic [kbrl_pkg::BATCH_W-1:0]  batch_size,
  input  logic [kbrl_pkg::HW_W-1:0]     high_water,
  input  logic                          action,
  input  logic [2:0]                    key,
  input  logic [7:0]                    weight,
  input  logic [15:0]                   tag,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          kind,
  output logic                          accepted,
  output logic [2:0]                    out_key,
  output logic [15:0]                   out_tag,
  output logic [7:0]                    out_weight,
  output logic                          last
);
  import kbrl_pkg::*;

  // lowest key at or above start that holds a bucket
  function automatic logic [KEY_W:0] first_ge(input logic [NUM_KEYS-1:0] vec,
                                              input logic [KEY_W:0] start);
    logic [KEY_W:0] res;
    res = '0;
    for (int k = NUM_KEYS - 1; k >= 0; k--) begin
      if (vec[k] && (k >= int'(start))) begin
        res = {1'b1, KEY_W'(k)};
      end
    end
    return res;
  endfunction

  // latched input word
  logic              r_action;
  logic [2:0]        r_key;
  logic [7:0]        r_weight;
  logic [15:0]       r_tag;

  // per-key state
  logic [QPTR_W-1:0] head  [NUM_KEYS];
  logic [CNT_W-1:0]  count [NUM_KEYS];
  logic [PEND_W-1:0] pend_w[NUM_KEYS];
  logic [DEBT_W-1:0] debt  [NUM_KEYS];

  logic [KEY_W-1:0]  resume_key;
  logic              resume_valid;

  // walk state
  logic [KEY_W-1:0]  it;
  logic              it_valid;
  logic [PROC_W-1:0] processed;

  // held dispatch word, sent once the next one or the end of the walk is known
  logic              pend_valid;
  logic [2:0]        pend_key;
  logic [15:0]       pend_tag;
  logic [7:0]        pend_weight;

  logic [23:0]       store [STORE_DEPTH];
  logic [23:0]       rd_data;

  logic [NUM_KEYS-1:0] bucket;
  always_comb begin
    for (int k = 0; k < NUM_KEYS; k++) begin
      bucket[k] = (count[k] != '0) || (debt[k] != '0);
    end
  end

  // enqueue checks
  logic [KEY_W-1:0]  ekey;
  logic              key_ok;
  logic [PEND_W:0]   esum;
  logic              enq_ok;
  logic [QPTR_W+1:0] eslot_sum;
  logic [QPTR_W-1:0] eslot;
  logic [ADDR_W-1:0] waddr;

  assign ekey   = KEY_W'(key_ok ? r_key : 3'd0);
  assign key_ok = (32'(r_key) < NUM_KEYS);
  assign esum   = {1'b0, pend_w[ekey]} + (PEND_W+1)'(r_weight);
  assign enq_ok = key_ok
               && (32'(count[ekey]) < QUEUE_DEPTH)
               && !((high_water != '0) && (esum > (PEND_W+1)'(high_water)))
               && !(esum > {1'b0, PEND_MAX});
  assign eslot_sum = (QPTR_W+2)'(head[ekey]) + (QPTR_W+2)'(count[ekey]);
  assign eslot     = (32'(eslot_sum) >= QUEUE_DEPTH)
                   ? QPTR_W'(32'(eslot_sum) - QUEUE_DEPTH) : QPTR_W'(eslot_sum);
  assign waddr     = ADDR_W'(32'(ekey) * QUEUE_DEPTH + 32'(eslot));

  // walk step on the current key
  logic [ADDR_W-1:0] raddr;
  logic [7:0]        dw;
  logic [8:0]        dcost;
  logic [PROC_W-1:0] proc_disp;
  logic [PROC_W-1:0] proc_new;
  logic [DEBT_W-1:0] debt_new;
  logic [CNT_W-1:0]  cnt_new;
  logic              keeps;
  logic [NUM_KEYS-1:0] bucket_new;
  logic [KEY_W:0]    nxt_up;
  logic [KEY_W:0]    nxt_wrap;
  logic [KEY_W:0]    nxt;
  logic [KEY_W:0]    first0;
  logic [QPTR_W-1:0] head_inc;

  assign raddr     = ADDR_W'(32'(it) * QUEUE_DEPTH + 32'(head[it]));
  assign head_inc  = (32'(head[it]) == QUEUE_DEPTH - 1) ? '0 : head[it] + 1'b1;
  assign dw        = rd_data[7:0];
  assign dcost     = (dw > 8'd1) ? {1'b0, dw} : 9'd1;
  assign proc_disp = processed + PROC_W'(dcost);

  always_comb begin
    if (cmd.pay) begin
      proc_new = processed + 1'b1;
      debt_new = debt[it] - 1'b1;
      cnt_new  = count[it];
    end else begin
      proc_new = proc_disp;
      cnt_new  = count[it] - 1'b1;
      if ((batch_size != '0) && (proc_disp > PROC_W'(batch_size))) begin
        debt_new = DEBT_W'(proc_disp - PROC_W'(batch_size));
      end else begin
        debt_new = debt[it];
      end
    end
    keeps      = (cnt_new != '0) || (debt_new != '0);
    bucket_new = bucket;
    bucket_new[it] = keeps;
  end

  assign nxt_up   = first_ge(bucket_new, (KEY_W+1)'(it) + 1'b1);
  assign nxt_wrap = first_ge(bucket_new, '0);
  assign nxt      = (!nxt_up[KEY_W] && keeps) ? nxt_wrap : nxt_up;
  assign first0   = first_ge(bucket, '0);

  logic out_free;
  assign out_free = !out_valid || out_ready;

  assign stat.is_tick     = (r_action == ACT_TICK);
  assign stat.out_free    = out_free;
  assign stat.any_bucket  = |bucket;
  assign stat.limit_hit   = (batch_size != '0) && (processed >= PROC_W'(batch_size));
  assign stat.it_valid    = it_valid;
  assign stat.cur_debt_nz = (debt[it] != '0);
  assign stat.pend_valid  = pend_valid;

  // action store
  always_ff @(posedge clk) begin
    if (cmd.enq && enq_ok) begin
      store[waddr] <= {r_tag, r_weight};
    end
    if (cmd.rd) begin
      rd_data <= store[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      r_action <= action;
      r_key    <= key;
      r_weight <= weight;
      r_tag    <= tag;
    end
    if (cmd.disp) begin
      pend_key    <= 3'(it);
      pend_tag    <= rd_data[23:8];
      pend_weight <= dw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        head[k]   <= '0;
        count[k]  <= '0;
        pend_w[k] <= '0;
        debt[k]   <= '0;
      end
      resume_key   <= '0;
      resume_valid <= 1'b0;
      it           <= '0;
      it_valid     <= 1'b0;
      processed    <= '0;
      pend_valid   <= 1'b0;
    end else begin
      if (cmd.enq && enq_ok) begin
        count[ekey]  <= count[ekey] + 1'b1;
        pend_w[ekey] <= esum[PEND_W-1:0];
      end
      if (cmd.tstart) begin
        it         <= (resume_valid && bucket[resume_key]) ? resume_key : first0[KEY_W-1:0];
        it_valid   <= 1'b1;
        processed  <= '0;
        pend_valid <= 1'b0;
      end
      if (cmd.pay || cmd.disp) begin
        processed <= proc_new;
        debt[it]  <= debt_new;
        if (cmd.disp) begin
          count[it]  <= cnt_new;
          head[it]   <= head_inc;
          pend_w[it] <= pend_w[it] - PEND_W'(dw);
          pend_valid <= 1'b1;
        end
        if (!keeps) begin
          resume_key   <= it;
          resume_valid <= 1'b1;
        end
        it       <= nxt[KEY_W-1:0];
        it_valid <= nxt[KEY_W];
      end
      if (cmd.finish) begin
        pend_valid <= 1'b0;
        if (it_valid) begin
          resume_key   <= it;
          resume_valid <= 1'b1;
        end
      end
    end
  end

  // output word register
  logic push;
  assign push = cmd.enq || (cmd.disp && pend_valid) || cmd.push_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.enq) begin
      kind       <= KIND_VERDICT;
      accepted   <= enq_ok;
      out_key    <= r_key;
      out_tag    <= '0;
      out_weight <= '0;
      last       <= 1'b1;
    end else if (push) begin
      kind       <= KIND_DISPATCH;
      accepted   <= 1'b0;
      out_key    <= pend_key;
      out_tag    <= pend_tag;
      out_weight <= pend_weight;
      last       <= cmd.push_last;
    end
  end

endmodule

// ----- hw/rtl/keyed_batch_rate_limiter_top.sv -----
// keyed_batch_rate_limiter_top: top level with register port, sequencer and datapath
// depends on kbrl_pkg, kbrl_ctrl and kbrl_dp
//
//   channel  signals                                   direction
//   in       in_valid/in_ready, action key weight tag  word into the block
//   out      out_valid/out_ready, kind accepted out_key
//            out_tag out_weight last                   word out of the block
//   cfg      psel penable pwrite paddr pwdata prdata   register access
//
// an enqueue latches the word, then sends its verdict once the output register is free
// a batch tick latches the word and returns to idle when no key holds a bucket; otherwise it
//   starts the walk, pays debt one unit per step, dispatches each action with a store read
//   and then an update (the store has a single read port), and closes the walk
// one word is held back so the final word of a tick can carry last
// rst is synchronous and clears all key state; no clearing pass is needed
// a stalled output holds the walk in place, nothing is dropped
module keyed_batch_rate_limiter_top (
  input  logic        clk,
  input  logic        rst,
  // item input
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        action,
  input  logic [2:0]  key,
  input  logic [7:0]  weight,
  input  logic [15:0] tag,
  // result output
  output logic        out_valid,
  input  logic        out_ready,
  output logic        kind,
  output logic        accepted,
  output logic [2:0]  out_key,
  output logic [15:0] out_tag,
  output logic [7:0]  out_weight,
  output logic        last,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import kbrl_pkg::*;

  logic [BATCH_W-1:0] batch_size;
  logic [HW_W-1:0]    high_water;
  kbrl_cmd_t          cmd;
  kbrl_stat_t         stat;

  assign pready = 1'b1;

  // register writes complete on the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      batch_size <= '0;
      high_water <= '0;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == ADDR_HIGH[2]) begin
        high_water <= pwdata[HW_W-1:0];
      end else begin
        batch_size <= pwdata[BATCH_W-1:0];
      end
    end
  end

  // register readback
  always_comb begin
    if (paddr[2] == ADDR_BATCH[2]) begin
      prdata = {{(32-BATCH_W){1'b0}}, batch_size};
    end else begin
      prdata = {{(32-HW_W){1'b0}}, high_water};
    end
  end

  kbrl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  kbrl_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .batch_size (batch_size),
    .high_water (high_water),
    .action     (action),
    .key        (key),
    .weight     (weight),
    .tag        (tag),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .kind       (kind),
    .accepted   (accepted),
    .out_key    (out_key),
    .out_tag    (out_tag),
    .out_weight (out_weight),
    .last       (last)
  );

endmodule

// ----- dv/tb_top.sv -----
// tb_top: self-checking bench for keyed_batch_rate_limiter_top, with a key queue
// predictor, a queue-fed word driver, a checking monitor and register writes
// depends on kbrl_pkg and keyed_batch_rate_limiter_top
module tb_top;
  import kbrl_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        action = 1'b0;
  logic [2:0]  key = '0;
  logic [7:0]  weight = '0;
  logic [15:0] tag = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        kind, accepted, last;
  logic [2:0]  out_key;
  logic [15:0] out_tag;
  logic [7:0]  out_weight;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  keyed_batch_rate_limiter_top u_top (.*);

  always #5 clk = ~clk;

  // one pending input word
  typedef struct {
    logic        act;
    logic [2:0]  k;
    logic [7:0]  w;
    logic [15:0] t;
  } req_t;

  // one expected output word
  typedef struct {
    logic        knd;
    logic        acc;
    logic [2:0]  k;
    logic [15:0] t;
    logic [7:0]  w;
    logic        lst;
  } word_t;

  req_t  req_q[$];
  word_t due_q[$];
  int    errors = 0;
  bit    tx_burst = 0, rx_burst = 0;

  // predictor state: per-key ring of {tag, weight}, counts, debt, walk position
  logic [23:0] ring_mem[NUM_KEYS*QUEUE_DEPTH];
  logic [2:0]  ring_head[NUM_KEYS];
  logic [3:0]  ring_cnt[NUM_KEYS];
  logic [10:0] pend_sum[NUM_KEYS];
  logic [7:0]  key_owed[NUM_KEYS];
  logic [2:0]  walk_key = '0;
  bit          walk_ok = 0;
  logic [6:0]  lim_batch = '0;
  logic [10:0] lim_water = '0;

  initial begin
    for (int i = 0; i < NUM_KEYS; i++) begin
      ring_head[i] = '0;
      ring_cnt[i] = '0;
      pend_sum[i] = '0;
      key_owed[i] = '0;
    end
  end

  function automatic bit busy_key(int k);
    return ring_cnt[k] != 0 || key_owed[k] != 0;
  endfunction

  function automatic int first_busy(int from);
    for (int k = from; k < NUM_KEYS; k++)
      if (busy_key(k)) return k;
    return -1;
  endfunction

  // verdict for an enqueue; accepted words land in the key's ring
  function automatic void admit(req_t r);
    int    sum;
    bit    ok;
    word_t v;
    sum = pend_sum[r.k] + r.w;
    ok = ring_cnt[r.k] < QUEUE_DEPTH && !(lim_water != 0 && sum > lim_water) && sum <= 2047;
    if (ok) begin
      ring_mem[r.k*QUEUE_DEPTH + ((ring_head[r.k] + ring_cnt[r.k]) % QUEUE_DEPTH)] = {r.t, r.w};
      ring_cnt[r.k] = ring_cnt[r.k] + 1;
      pend_sum[r.k] = sum;
    end
    v = '{KIND_VERDICT, ok, r.k, 16'h0, 8'h0, 1'b1};
    due_q.push_back(v);
  endfunction

  // one batch pass: round robin over busy keys, paying debt or dispatching heads
  function automatic void batch_pass();
    int          it, k, used, n;
    logic [23:0] e;
    word_t       v;
    n = 0;
    used = 0;
    if (first_busy(0) < 0) return;
    it = (walk_ok && busy_key(walk_key)) ? int'(walk_key) : first_busy(0);
    while ((lim_batch == 0 || used < lim_batch) && it >= 0) begin
      k = it;
      if (key_owed[k] == 0) begin
        e = ring_mem[k*QUEUE_DEPTH + ring_head[k]];
        ring_head[k] = ring_head[k] + 1;
        ring_cnt[k] = ring_cnt[k] - 1;
        pend_sum[k] = pend_sum[k] - e[7:0];
        used += (e[7:0] > 1) ? e[7:0] : 1;
        if (lim_batch != 0 && used > lim_batch) key_owed[k] = key_owed[k] + (used - lim_batch);
        v = '{KIND_DISPATCH, 1'b0, k[2:0], e[23:8], e[7:0], 1'b0};
        due_q.push_back(v);
        n++;
      end else begin
        key_owed[k] = key_owed[k] - 1;
        used++;
      end
      if (!busy_key(k)) begin
        // quirk: the emptied key becomes the resume point
        walk_key = k[2:0];
        walk_ok = 1;
        it = first_busy(k + 1);
      end else begin
        it = first_busy(k + 1);
        if (it < 0) it = first_busy(0);
      end
    end
    if (it >= 0) begin
      walk_key = it[2:0];
      walk_ok = 1;
    end
    if (n > 0) due_q[due_q.size()-1].lst = 1'b1;
  endfunction

  // driver: a word, then a drawn gap; valid holds until the handshake
  int tx_gap = 0;
  always @(posedge clk) begin : drv
    req_t r;
    if (rst) begin
      in_valid <= 1'b0;
      tx_gap <= 0;
    end else begin
      if (in_valid && in_ready) begin
        r = '{action, key, weight, tag};
        if (r.act == ACT_ENQ) admit(r);
        else batch_pass();
      end
      if (!in_valid || in_ready) begin
        if (tx_gap != 0) begin
          tx_gap <= tx_gap - 1;
          in_valid <= 1'b0;
        end else if (req_q.size() > 0) begin
          r = req_q.pop_front();
          in_valid <= 1'b1;
          action <= r.act;
          key <= r.k;
          weight <= r.w;
          tag <= r.t;
          tx_gap <= tx_burst ? 0 : $urandom_range(0, 14);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each word against the oldest expectation, draws stalls,
  // and once holds off for a long stretch so the block backs up its input
  int rx_stall = 0;
  int rx_count = 0;
  always @(posedge clk) begin : mon
    word_t exp_w;
    word_t got;
    int    s;
    if (rst) begin
      out_ready <= 1'b0;
      rx_stall <= 0;
    end else if (out_valid && out_ready) begin
      got = '{kind, accepted, out_key, out_tag, out_weight, last};
      if (due_q.size() == 0) begin
        $display("%0t: unexpected word, actual %p", $time, got);
        errors++;
      end else begin
        exp_w = due_q.pop_front();
        if (got.knd !== exp_w.knd || got.acc !== exp_w.acc || got.k !== exp_w.k ||
            got.t !== exp_w.t || got.w !== exp_w.w || got.lst !== exp_w.lst) begin
          $display("%0t: mismatch, expected %p, actual %p", $time, exp_w, got);
          errors++;
        end
      end
      rx_count <= rx_count + 1;
      s = (rx_count == 40) ? 400 : (rx_burst ? 0 : $urandom_range(0, 14));
      rx_stall <= s;
      out_ready <= (s == 0);
    end else if (rx_stall > 0) begin
      rx_stall <= rx_stall - 1;
      out_ready <= (rx_stall == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // setup cycle then access cycle; the register takes the value on the access edge
  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_BATCH) lim_batch = data[6:0];
    else lim_water = data[10:0];
  endtask

  // sender pauses until every expected word is back and the block is idle
  // again, so a walk that only pays debt (no words) has finished too
  task automatic drain();
    while (req_q.size() > 0 || in_valid || due_q.size() > 0 || !in_ready) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic add_enq(input int k, input int w, input int t);
    req_t r;
    r = '{ACT_ENQ, k[2:0], w[7:0], t[15:0]};
    req_q.push_back(r);
  endtask

  task automatic add_tick();
    req_t r;
    r = '{ACT_TICK, 3'($urandom), 8'($urandom), 16'($urandom)};
    req_q.push_back(r);
  endtask

  int batch_set[6] = '{0, 1, 64, 127, 5, 32};
  int water_set[6] = '{0, 0, 2047, 500, 60, 0};

  initial begin
    int w;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: tick with nothing queued, field extremes, full queue, unlimited drain
    add_tick();
    add_enq(0, 0, 16'h0000);
    add_enq(7, 255, 16'hffff);
    add_enq(5, 1, 16'ha5a5);
    for (int i = 0; i < 8; i++) add_enq(7, 255, 16'h5a00 + i);
    add_tick();
    drain();

    // directed: one unit per tick, high-water edge, heavy debt from a big weight
    reg_write(ADDR_BATCH, 32'd1);
    reg_write(ADDR_HIGH, 32'd300);
    add_enq(2, 200, 16'h1234);
    add_enq(2, 200, 16'h4321);
    add_enq(2, 100, 16'hbeef);
    add_enq(3, 5, 16'h0f0f);
    add_tick();
    add_tick();
    add_tick();
    drain();

    // random phases across register settings
    for (int p = 0; p < 6; p++) begin
      reg_write(ADDR_BATCH, batch_set[p]);
      reg_write(ADDR_HIGH, water_set[p]);
      tx_burst = (p % 3 == 1);
      rx_burst = (p % 3 == 2);
      for (int i = 0; i < 32; i++) begin
        if ($urandom_range(0, 4) == 0) begin
          add_tick();
        end else begin
          case ($urandom_range(0, 3))
            0: w = $urandom_range(0, 1) ? 255 : 0;
            1: w = $urandom_range(0, 255);
            default: w = $urandom_range(0, 15);
          endcase
          add_enq($urandom_range(0, 7), w, $urandom_range(0, 65535));
        end
      end
      drain();
    end

    // unlimited pass to flush anything left
    reg_write(ADDR_BATCH, 32'd0);
    add_tick();
    drain();

    if (errors == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

  initial begin
    #20000000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/kbrl_pkg.sv
hw/rtl/kbrl_ctrl.sv
hw/rtl/kbrl_dp.sv
hw/rtl/keyed_batch_rate_limiter_top.sv
dv/tb_top.sv
